FILE: src/zlrc_pkg.sv
// Shared types and constants for the zoned lock reference counter.
// No dependencies; imported by zlrc_update and the top level.
package zlrc_pkg;

	// field widths fixed by the request format
	localparam int LOCK_IW = 8;
	localparam int ZONE_IW = 4;
	localparam int CNT_W   = 16;
	localparam int HOLD_W  = 5;

	localparam logic [CNT_W-1:0]  CNT_MAX     = 16'hFFFF;
	localparam logic [HOLD_W-1:0] HOLDERS_MAX = 5'd31;

	// request modes
	localparam logic [3:0] MODE_INIT       = 4'd0;
	localparam logic [3:0] MODE_ACQUIRE    = 4'd1;
	localparam logic [3:0] MODE_RELEASE    = 4'd2;
	localparam logic [3:0] MODE_JREL       = 4'd3;
	localparam logic [3:0] MODE_JREL_OTHER = 4'd4;
	localparam logic [3:0] MODE_ACK        = 4'd5;
	localparam logic [3:0] MODE_SUSPEND    = 4'd6;
	localparam logic [3:0] MODE_RESUME     = 4'd7;
	localparam logic [3:0] MODE_QUERY      = 4'd8;

	// notification machine
	localparam logic [1:0] NS_IDLE      = 2'd0;
	localparam logic [1:0] NS_NOTIFYING = 2'd1;
	localparam logic [1:0] NS_SUSPENDED = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_LOCKS    = 2'd0;
	localparam logic [1:0] CFG_LOGICAL  = 2'd1;
	localparam logic [1:0] CFG_PHYSICAL = 2'd2;

	// request as held in the update stage
	typedef struct packed {
		logic [3:0]       mode;
		logic             kind;
		logic             bad;
		logic [CNT_W-1:0] init;
	} zlrc_req_t;

	// one word of the per-lock memory
	typedef struct packed {
		logic [CNT_W-1:0]  jc;
		logic [CNT_W-1:0]  jd;
		logic [HOLD_W-1:0] lh;
		logic [HOLD_W-1:0] ph;
	} zlrc_lock_t;

	// result item
	typedef struct packed {
		logic locked;
		logic notify;
		logic accepted;
		logic error;
	} zlrc_res_t;

endpackage

FILE: src/zlrc_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// No dependencies.
module zlrc_ram #(
	parameter int W  = 16,
	parameter int AW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [(1 << AW)];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/zlrc_update.sv
// Modify step of the read-modify-write: new lock word, zone count,
// notification state and result item. Depends on zlrc_pkg.
module zlrc_update import zlrc_pkg::*; (
	input  zlrc_req_t         req,
	input  zlrc_lock_t        lock_rd,
	input  logic [CNT_W-1:0]  ref_rd,
	input  logic [1:0]        ns,
	output zlrc_lock_t        lock_new,
	output logic              lock_we,
	output logic [CNT_W-1:0]  ref_new,
	output logic              ref_we,
	output logic [1:0]        ns_new,
	output zlrc_res_t         res
);

	logic [HOLD_W-1:0] h;
	logic [HOLD_W-1:0] h_new;
	logic [CNT_W-1:0]  jc_dec;

	assign h      = req.kind ? lock_rd.ph : lock_rd.lh;
	assign jc_dec = lock_rd.jc - 16'd1;

	always_comb begin
		lock_new  = lock_rd;
		lock_we   = 1'b0;
		ref_new   = ref_rd;
		ref_we    = 1'b0;
		ns_new    = ns;
		h_new     = h;
		res       = '0;
		res.error = req.bad;
		case (req.mode)
			MODE_INIT: begin
				if (!req.bad) begin
					lock_new.jc = req.init;
					lock_new.jd = '0;
					lock_we     = 1'b1;
				end
			end
			MODE_ACQUIRE: begin
				if (!req.bad) begin
					if (ref_rd == CNT_MAX) begin
						res.error = 1'b1;
					end else begin
						ref_new = ref_rd + 16'd1;
						ref_we  = 1'b1;
						// first reference from this zone
						if (ref_rd == '0 && h < HOLDERS_MAX) begin
							h_new   = h + 5'd1;
							lock_we = 1'b1;
						end
					end
				end
			end
			MODE_RELEASE: begin
				if (!req.bad) begin
					if (ref_rd == '0) begin
						res.error = 1'b1;
					end else begin
						ref_new = ref_rd - 16'd1;
						ref_we  = 1'b1;
						// last reference from this zone
						if (ref_rd == 16'd1 && h != '0) begin
							h_new   = h - 5'd1;
							lock_we = 1'b1;
							if (h == 5'd1 && ns == NS_IDLE) begin
								ns_new     = NS_NOTIFYING;
								res.notify = 1'b1;
							end
						end
					end
				end
			end
			MODE_JREL: begin
				if (!req.bad) begin
					if (lock_rd.jc <= lock_rd.jd) begin
						res.error = 1'b1;
					end else begin
						lock_new.jc = jc_dec;
						lock_we     = 1'b1;
						if (jc_dec == lock_rd.jd && ns == NS_IDLE) begin
							ns_new     = NS_NOTIFYING;
							res.notify = 1'b1;
						end
					end
				end
			end
			MODE_JREL_OTHER: begin
				if (!req.bad) begin
					if (lock_rd.jd >= lock_rd.jc) begin
						res.error = 1'b1;
					end else begin
						lock_new.jd = lock_rd.jd + 16'd1;
						lock_we     = 1'b1;
					end
				end
			end
			MODE_ACK: begin
				ns_new = NS_IDLE;
			end
			MODE_SUSPEND: begin
				if (ns == NS_IDLE) begin
					ns_new       = NS_SUSPENDED;
					res.accepted = 1'b1;
				end else if (ns == NS_SUSPENDED) begin
					res.accepted = 1'b1;
				end
			end
			MODE_RESUME: begin
				if (ns == NS_SUSPENDED) begin
					ns_new       = NS_IDLE;
					res.accepted = 1'b1;
				end
			end
			MODE_QUERY: begin
				if (!req.bad) begin
					res.locked = (lock_rd.jc != lock_rd.jd) || (h != '0);
				end
			end
			default: begin
			end
		endcase
		// put the holder count back for the zone type concerned
		if (req.kind) begin
			lock_new.ph = h_new;
		end else begin
			lock_new.lh = h_new;
		end
	end

endmodule

FILE: src/zoned_lock_reference_counter_unit.sv
// Zoned lock reference counter: per-lock journal and zone reference counts
// kept in two synchronous memories. Top level; depends on zlrc_pkg,
// zlrc_ram and zlrc_update.
//
// For each request the lock and zone memories are read in the cycle the item
// is accepted; the update stage modifies and writes back once the result
// register is free or its result is being taken, producing one result item.
// in_stall stays high while an item sits in the update stage, so requests to
// the same lock never overlap. The result register lets the next item enter
// while a result waits to be taken. After reset the block clears both
// memories, one entry a cycle, visiting every zone memory address; in_stall
// is high during that pass, configuration writes are taken as ever.
// Configuration must only be written while no item is in flight.
module zoned_lock_reference_counter_unit import zlrc_pkg::*; #(
	parameter int MAX_LOCKS          = 256,
	parameter int MAX_LOGICAL_ZONES  = 16,
	parameter int MAX_PHYSICAL_ZONES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  mode,
	input  logic [7:0]  lock_index,
	input  logic        zone_kind,
	input  logic [3:0]  zone_index,
	input  logic [15:0] initial_count,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        locked,
	output logic        notify,
	output logic        accepted,
	output logic        error
);

	localparam int ZMAX = (MAX_LOGICAL_ZONES > MAX_PHYSICAL_ZONES) ?
		MAX_LOGICAL_ZONES : MAX_PHYSICAL_ZONES;
	localparam int LW   = (MAX_LOCKS > 1) ? $clog2(MAX_LOCKS) : 1;
	localparam int ZW   = (ZMAX > 1) ? $clog2(ZMAX) : 1;
	localparam int ZAW  = 1 + ZW + LW;
	localparam int LKW  = $bits(zlrc_lock_t);

	localparam logic [12:0] MAX_LOCKS_V = 13'(MAX_LOCKS);
	localparam logic [6:0]  MAX_LZ_V    = 7'(MAX_LOGICAL_ZONES);
	localparam logic [6:0]  MAX_PZ_V    = 7'(MAX_PHYSICAL_ZONES);

	// configuration registers
	logic [8:0] locks_q;
	logic [4:0] lzones_q;
	logic [4:0] pzones_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locks_q  <= 9'd256;
			lzones_q <= 5'd1;
			pzones_q <= 5'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOCKS:    locks_q  <= cfg_data;
				CFG_LOGICAL:  lzones_q <= cfg_data[4:0];
				CFG_PHYSICAL: pzones_q <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	// clearing pass after reset
	logic           clearing_q;
	logic [ZAW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == '1) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// range checks and addresses at accept
	logic               acc;
	logic               valid_s1;
	logic               lock_ok;
	logic               zone_ok;
	logic [4:0]         zcfg;
	logic [6:0]         zmax;
	logic               bad;
	logic [LW+LOCK_IW-1:0] lock_ext;
	logic [ZW+ZONE_IW-1:0] zone_ext;
	logic [LW-1:0]      lock_addr;
	logic [ZAW-1:0]     zone_addr;

	assign in_stall = clearing_q || valid_s1;
	assign acc      = in_valid && !in_stall;

	assign lock_ok = ({1'b0, lock_index} < locks_q) &&
		({5'b0, lock_index} < MAX_LOCKS_V);
	assign zcfg    = zone_kind ? pzones_q : lzones_q;
	assign zmax    = zone_kind ? MAX_PZ_V : MAX_LZ_V;
	assign zone_ok = ({1'b0, zone_index} < zcfg) && ({3'b0, zone_index} < zmax);

	assign bad = (!lock_ok && (mode == MODE_INIT || mode == MODE_ACQUIRE ||
		mode == MODE_RELEASE || mode == MODE_JREL || mode == MODE_JREL_OTHER ||
		mode == MODE_QUERY)) ||
		(!zone_ok && (mode == MODE_ACQUIRE || mode == MODE_RELEASE));

	assign lock_ext  = {{LW{1'b0}}, lock_index};
	assign zone_ext  = {{ZW{1'b0}}, zone_index};
	assign lock_addr = lock_ext[LW-1:0];
	assign zone_addr = {zone_kind, zone_ext[ZW-1:0], lock_addr};

	// update stage registers
	zlrc_req_t      req_s1;
	logic [LW-1:0]  lock_addr_s1;
	logic [ZAW-1:0] zone_addr_s1;
	logic           adv;
	logic           out_valid_q;

	assign adv = valid_s1 && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_s1.mode  <= mode;
			req_s1.kind  <= zone_kind;
			req_s1.bad   <= bad;
			req_s1.init  <= initial_count;
			lock_addr_s1 <= lock_addr;
			zone_addr_s1 <= zone_addr;
		end
	end

	// memories
	zlrc_lock_t       lock_rd;
	zlrc_lock_t       lock_new;
	logic [LKW-1:0]   lock_rd_w;
	logic [CNT_W-1:0] ref_rd;
	logic [CNT_W-1:0] ref_new;
	logic             lock_we;
	logic             ref_we;
	logic             lock_wen;
	logic             ref_wen;
	logic [LW-1:0]    lock_waddr;
	logic [ZAW-1:0]   zone_waddr;
	logic [LKW-1:0]   lock_wdata;
	logic [CNT_W-1:0] ref_wdata;

	assign lock_wen   = clearing_q || (adv && lock_we);
	assign ref_wen    = clearing_q || (adv && ref_we);
	assign lock_waddr = clearing_q ? clr_q[LW-1:0] : lock_addr_s1;
	assign zone_waddr = clearing_q ? clr_q : zone_addr_s1;
	assign lock_wdata = clearing_q ? '0 : lock_new;
	assign ref_wdata  = clearing_q ? '0 : ref_new;
	assign lock_rd    = lock_rd_w;

	zlrc_ram #(.W(LKW), .AW(LW)) u_lock_ram (
		.clk   (clk),
		.we    (lock_wen),
		.waddr (lock_waddr),
		.wdata (lock_wdata),
		.re    (acc),
		.raddr (lock_addr),
		.rdata (lock_rd_w)
	);

	zlrc_ram #(.W(CNT_W), .AW(ZAW)) u_zone_ram (
		.clk   (clk),
		.we    (ref_wen),
		.waddr (zone_waddr),
		.wdata (ref_wdata),
		.re    (acc),
		.raddr (zone_addr),
		.rdata (ref_rd)
	);

	// modify step
	logic [1:0] ns_q;
	logic [1:0] ns_new;
	zlrc_res_t  res;

	zlrc_update u_update (
		.req      (req_s1),
		.lock_rd  (lock_rd),
		.ref_rd   (ref_rd),
		.ns       (ns_q),
		.lock_new (lock_new),
		.lock_we  (lock_we),
		.ref_new  (ref_new),
		.ref_we   (ref_we),
		.ns_new   (ns_new),
		.res      (res)
	);

	// notification machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ns_q <= NS_IDLE;
		end else if (adv) begin
			ns_q <= ns_new;
		end
	end

	// result register
	zlrc_res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign locked    = res_q.locked;
	assign notify    = res_q.notify;
	assign accepted  = res_q.accepted;
	assign error     = res_q.error;

	// checks
	a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !valid_s1)
		else $error("item in update stage during clearing pass");

	a_ns_code: assert property (@(posedge clk) disable iff (!arst_n)
		ns_q != 2'd3)
		else $error("notification state left its codes");

	a_notify_sets_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.notify |=> ns_q == NS_NOTIFYING)
		else $error("notification fired without entering notifying");

	a_error_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.error |-> !lock_we && !ref_we && !res.notify)
		else $error("update written back for a failed request");

endmodule
